[src/tpq_pkg.sv]
package tpq_pkg;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_PEEK    = 2'd1;
    localparam logic [1:0] OP_CONFIRM = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_NOTHING  = 3'd1;
    localparam logic [2:0] STATUS_FULL     = 3'd2;
    localparam logic [2:0] STATUS_NOSEL    = 3'd3;
    localparam logic [2:0] STATUS_MISMATCH = 3'd4;
    localparam logic [2:0] STATUS_SELEMPTY = 3'd5;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } ring_ctrl_t;

    typedef struct packed {
        logic empty;
        logic one;
        logic full;
    } ring_flags_t;

endpackage

[src/two_priority_queue_with_confirm.sv]
// An input transfer moves the block from S_IDLE to S_EXEC and reads the ring heads;
// the queue update and the result registers commit as the block leaves S_EXEC.
// in_stall is high outside S_IDLE, so no new item is taken until the current one
// commits, after the synchronous store read and the read-modify-write that follows it.
// A stalled result holds the block in its update cycle until the transfer.
// Reset clears queue pointers, counts, selection and result valid;
// the tag stores are not cleared.
module two_priority_queue_with_confirm #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic                urgent,
    input  logic [TAG_BITS-1:0] item_tag,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [TAG_BITS-1:0] head_tag,
    output logic                from_urgent,
    output logic                all_empty
);
    import tpq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    logic [1:0]          op_reg;
    logic                urgent_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic sel_valid_reg;
    logic sel_valid_next;
    logic sel_urgent_reg;
    logic sel_urgent_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [2:0]          status_reg;
    logic [2:0]          status_next;
    logic [TAG_BITS-1:0] head_tag_reg;
    logic [TAG_BITS-1:0] head_tag_next;
    logic                from_urgent_reg;
    logic                from_urgent_next;
    logic                all_empty_reg;
    logic                all_empty_next;

    logic                in_xfer;
    logic                commit;
    logic                pick_urgent;
    logic                sel_empty;
    logic [TAG_BITS-1:0] sel_head;

    ring_ctrl_t          u_ctrl_raw;
    ring_ctrl_t          n_ctrl_raw;
    ring_ctrl_t          u_ctrl;
    ring_ctrl_t          n_ctrl;
    ring_flags_t         u_flags;
    ring_flags_t         n_flags;
    logic [TAG_BITS-1:0] u_head;
    logic [TAG_BITS-1:0] n_head;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    tpq_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_urgent_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_xfer),
        .ctrl      (u_ctrl),
        .wr_data   (tag_reg),
        .head_data (u_head),
        .flags     (u_flags)
    );

    tpq_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_normal_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_xfer),
        .ctrl      (n_ctrl),
        .wr_data   (tag_reg),
        .head_data (n_head),
        .flags     (n_flags)
    );

    assign pick_urgent = !u_flags.empty;
    assign sel_empty   = sel_urgent_reg ? u_flags.empty : n_flags.empty;
    assign sel_head    = sel_urgent_reg ? u_head : n_head;

    always_comb
    begin
        u_ctrl_raw       = '0;
        n_ctrl_raw       = '0;
        status_next      = STATUS_OK;
        head_tag_next    = '0;
        from_urgent_next = 1'b0;
        sel_valid_next   = sel_valid_reg;
        sel_urgent_next  = sel_urgent_reg;
        case (op_reg)
            OP_PUSH:
            begin
                if (urgent_reg ? u_flags.full : n_flags.full)
                begin
                    status_next = STATUS_FULL;
                end
                else if (urgent_reg)
                begin
                    u_ctrl_raw.push = 1'b1;
                end
                else
                begin
                    n_ctrl_raw.push = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (u_flags.empty && n_flags.empty)
                begin
                    status_next = STATUS_NOTHING;
                end
                else
                begin
                    head_tag_next    = pick_urgent ? u_head : n_head;
                    from_urgent_next = pick_urgent;
                    sel_valid_next   = 1'b1;
                    sel_urgent_next  = pick_urgent;
                end
            end
            OP_CONFIRM:
            begin
                if (!sel_valid_reg)
                begin
                    status_next = STATUS_NOSEL;
                end
                else if (sel_empty)
                begin
                    status_next = STATUS_SELEMPTY;
                end
                else
                begin
                    sel_valid_next = 1'b0;
                    if (sel_head != tag_reg)
                    begin
                        status_next = STATUS_MISMATCH;
                    end
                    else if (sel_urgent_reg)
                    begin
                        u_ctrl_raw.pop = 1'b1;
                    end
                    else
                    begin
                        n_ctrl_raw.pop = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                u_ctrl_raw.clear = 1'b1;
                n_ctrl_raw.clear = 1'b1;
                sel_valid_next   = 1'b0;
                sel_urgent_next  = 1'b0;
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    assign u_ctrl = commit ? u_ctrl_raw : '0;
    assign n_ctrl = commit ? n_ctrl_raw : '0;

    // Emptiness after this step; push and pop never share a step.
    assign all_empty_next =
        (u_ctrl_raw.clear || (u_flags.empty && !u_ctrl_raw.push)
            || (u_flags.one && u_ctrl_raw.pop))
        && (n_ctrl_raw.clear || (n_flags.empty && !n_ctrl_raw.push)
            || (n_flags.one && n_ctrl_raw.pop));

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            sel_valid_reg  <= 1'b0;
            sel_urgent_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                sel_valid_reg  <= sel_valid_next;
                sel_urgent_reg <= sel_urgent_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg     <= operation;
            urgent_reg <= urgent;
            tag_reg    <= item_tag;
        end
        if (commit)
        begin
            status_reg      <= status_next;
            head_tag_reg    <= head_tag_next;
            from_urgent_reg <= from_urgent_next;
            all_empty_reg   <= all_empty_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign head_tag    = head_tag_reg;
    assign from_urgent = from_urgent_reg;
    assign all_empty   = all_empty_reg;

endmodule

[src/tpq_ring.sv]
module tpq_ring #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  tpq_pkg::ring_ctrl_t  ctrl,
    input  logic [TAG_BITS-1:0]  wr_data,
    output logic [TAG_BITS-1:0]  head_data,
    output tpq_pkg::ring_flags_t flags
);
    import tpq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [TAG_BITS-1:0] mem [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] head_reg;

    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (ctrl.clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            count_next  = '0;
        end
        else if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the tail on push, read the head when an item is taken in.
    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

    assign head_data   = head_reg;
    assign flags.empty = (count_reg == '0);
    assign flags.one   = (count_reg == CNT_ONE);
    assign flags.full  = (count_reg == CNT_FULL);

endmodule

[src/tpq_checker.sv]
module tpq_checker #(
    parameter int TAG_BITS = 32
) (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [2:0]          status,
    input logic [TAG_BITS-1:0] head_tag,
    input logic                from_urgent,
    input logic                all_empty
);
    import tpq_pkg::*;

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(head_tag) && $stable(from_urgent) && $stable(all_empty))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && from_urgent |-> status == STATUS_OK && !all_empty)
        else $error("urgent head flagged on a failed peek");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head_tag != '0 |-> status == STATUS_OK && !all_empty)
        else $error("head tag returned without a successful peek");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_NOTHING |-> all_empty)
        else $error("nothing queued reported while queues hold tags");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FULL |-> !all_empty)
        else $error("full queue reported with both queues empty");

endmodule

bind two_priority_queue_with_confirm tpq_checker #(
    .TAG_BITS (TAG_BITS)
) u_tpq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .head_tag    (head_tag),
    .from_urgent (from_urgent),
    .all_empty   (all_empty)
);

[tb/sv/queue_result_checker.sv]
module queue_result_checker #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          operation,
    input  logic                urgent,
    input  logic [TAG_BITS-1:0] item_tag,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [2:0]          status,
    input  logic [TAG_BITS-1:0] head_tag,
    input  logic                from_urgent,
    input  logic                all_empty,
    output int                  fail_count,
    output int                  pending,
    output int                  results_checked,
    output logic [7:0]          status_seen
);
    import tpq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]          st;
        logic [TAG_BITS-1:0] head;
        logic                from_urg;
        logic                empty_after;
    } queue_result_t;

    // index 1 is the urgent ring, index 0 the normal ring
    logic [TAG_BITS-1:0] slots [2][QUEUE_DEPTH];
    int                  rd_ptr [2];
    int                  wr_ptr [2];
    int                  fill [2];
    logic                sel_valid;
    logic                sel_urgent;

    queue_result_t expected_results[$];
    queue_result_t predicted;
    queue_result_t oldest;

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        fail_count++;
        if (fail_count <= 40)
            $display("%0t: mismatch on %s at result %0d: expected %0h, got %0h",
                     $realtime, field, results_checked, want, got);
    endtask

    task automatic apply_queue_op(input logic [1:0] op, input logic urg,
                                  input logic [TAG_BITS-1:0] tag,
                                  output queue_result_t r);
        int q;
        r = '0;
        r.st = STATUS_OK;
        case (op)
            OP_PUSH:
            begin
                q = urg ? 1 : 0;
                if (fill[q] >= QUEUE_DEPTH)
                    r.st = STATUS_FULL;
                else
                begin
                    slots[q][wr_ptr[q]] = tag;
                    wr_ptr[q] = (wr_ptr[q] + 1) % QUEUE_DEPTH;
                    fill[q]++;
                end
            end
            OP_PEEK:
            begin
                if (fill[0] == 0 && fill[1] == 0)
                    r.st = STATUS_NOTHING;
                else
                begin
                    q = (fill[1] != 0) ? 1 : 0;
                    r.head = slots[q][rd_ptr[q]];
                    r.from_urg = q[0];
                    sel_valid = 1'b1;
                    sel_urgent = q[0];
                end
            end
            OP_CONFIRM:
            begin
                q = sel_urgent ? 1 : 0;
                if (!sel_valid)
                    r.st = STATUS_NOSEL;
                else if (fill[q] == 0)
                    r.st = STATUS_SELEMPTY;
                else
                begin
                    // a confirm drops the selection whether or not the tag matches
                    sel_valid = 1'b0;
                    if (slots[q][rd_ptr[q]] != tag)
                        r.st = STATUS_MISMATCH;
                    else
                    begin
                        rd_ptr[q] = (rd_ptr[q] + 1) % QUEUE_DEPTH;
                        fill[q]--;
                    end
                end
            end
            default:
            begin
                rd_ptr = '{0, 0};
                wr_ptr = '{0, 0};
                fill = '{0, 0};
                sel_valid = 1'b0;
                sel_urgent = 1'b0;
            end
        endcase
        r.empty_after = (fill[0] == 0 && fill[1] == 0);
    endtask

    initial
    begin
        fail_count = 0;
        results_checked = 0;
        pending = 0;
        status_seen = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            rd_ptr = '{0, 0};
            wr_ptr = '{0, 0};
            fill = '{0, 0};
            sel_valid = 1'b0;
            sel_urgent = 1'b0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing outstanding", '0, 64'(status));
                else
                begin
                    oldest = expected_results.pop_front();
                    status_seen[oldest.st] = 1'b1;
                    if (status !== oldest.st)
                        report_mismatch("status", 64'(oldest.st), 64'(status));
                    if (head_tag !== oldest.head)
                        report_mismatch("head_tag", 64'(oldest.head), 64'(head_tag));
                    if (from_urgent !== oldest.from_urg)
                        report_mismatch("from_urgent", 64'(oldest.from_urg),
                                        64'(from_urgent));
                    if (all_empty !== oldest.empty_after)
                        report_mismatch("all_empty", 64'(oldest.empty_after),
                                        64'(all_empty));
                end
            end
            if (in_valid && !in_stall)
            begin
                apply_queue_op(operation, urgent, item_tag, predicted);
                expected_results.push_back(predicted);
            end
            pending = expected_results.size();
        end
    end

endmodule

[tb/sv/tb_two_priority_queue_with_confirm.sv]
module tb_two_priority_queue_with_confirm;
    import tpq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 32;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200_000;

    typedef enum int { DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_TOGGLE } drain_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          operation = OP_PUSH;
    logic                urgent = 1'b0;
    logic [TAG_BITS-1:0] item_tag = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [2:0]          status;
    logic [TAG_BITS-1:0] head_tag;
    logic                from_urgent;
    logic                all_empty;

    int         fail_count;
    int         pending;
    int         results_checked;
    logic [7:0] status_seen;

    int cycle_count = 0;
    int input_stall_cycles = 0;
    int items_sent = 0;
    int op_count[4] = '{0, 0, 0, 0};
    int burst_left = 0;
    bit bursts_on = 1'b1;
    bit hold_request = 1'b0;

    // tags the block should hold, kept to build matching confirms and to size fills and drains
    logic [TAG_BITS-1:0] queued_urgent_tags[$];
    logic [TAG_BITS-1:0] queued_normal_tags[$];
    bit picked_valid = 1'b0;
    bit picked_urgent = 1'b0;

    two_priority_queue_with_confirm #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TAG_BITS(TAG_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .urgent(urgent),
        .item_tag(item_tag),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .head_tag(head_tag),
        .from_urgent(from_urgent),
        .all_empty(all_empty)
    );

    queue_result_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TAG_BITS(TAG_BITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .urgent(urgent),
        .item_tag(item_tag),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .head_tag(head_tag),
        .from_urgent(from_urgent),
        .all_empty(all_empty),
        .fail_count(fail_count),
        .pending(pending),
        .results_checked(results_checked),
        .status_seen(status_seen)
    );

    always #5ns clk = ~clk;

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (in_valid && in_stall)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall modes, plus one long hold on request
    initial
    begin : receiver
        int          mode_left;
        int          hold_left;
        drain_mode_t mode;
        mode_left = 0;
        hold_left = 0;
        mode = DRAIN_FREE;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = drain_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    DRAIN_FREE:  out_stall <= 1'b0;
                    DRAIN_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
                    DRAIN_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    function automatic logic [TAG_BITS-1:0] pick_tag();
        logic [TAG_BITS-1:0] one_hot;
        one_hot = '0;
        one_hot[$urandom_range(0, TAG_BITS - 1)] = 1'b1;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TAG_BITS-1:0] head_to_confirm();
        if (picked_valid && picked_urgent && queued_urgent_tags.size() != 0)
            return queued_urgent_tags[0];
        if (picked_valid && !picked_urgent && queued_normal_tags.size() != 0)
            return queued_normal_tags[0];
        return pick_tag();
    endfunction

    task automatic note_issued(input logic [1:0] op, input logic urg,
                               input logic [TAG_BITS-1:0] tag);
        case (op)
            OP_PUSH:
            begin
                if (urg && queued_urgent_tags.size() < QUEUE_DEPTH)
                    queued_urgent_tags.push_back(tag);
                else if (!urg && queued_normal_tags.size() < QUEUE_DEPTH)
                    queued_normal_tags.push_back(tag);
            end
            OP_PEEK:
            begin
                if (queued_urgent_tags.size() != 0 || queued_normal_tags.size() != 0)
                begin
                    picked_valid = 1'b1;
                    picked_urgent = (queued_urgent_tags.size() != 0);
                end
            end
            OP_CONFIRM:
            begin
                if (picked_valid && picked_urgent && queued_urgent_tags.size() != 0)
                begin
                    picked_valid = 1'b0;
                    if (queued_urgent_tags[0] == tag)
                        void'(queued_urgent_tags.pop_front());
                end
                else if (picked_valid && !picked_urgent && queued_normal_tags.size() != 0)
                begin
                    picked_valid = 1'b0;
                    if (queued_normal_tags[0] == tag)
                        void'(queued_normal_tags.pop_front());
                end
            end
            default:
            begin
                queued_urgent_tags.delete();
                queued_normal_tags.delete();
                picked_valid = 1'b0;
            end
        endcase
    endtask

    // offer one item, inserting a gap between bursts; returns after the transfer
    task automatic offer(input logic [1:0] op, input logic urg,
                         input logic [TAG_BITS-1:0] tag);
        int gap;
        if (bursts_on && burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        note_issued(op, urg, tag);
        in_valid <= 1'b1;
        operation <= op;
        urgent <= urg;
        item_tag <= tag;
        do @(posedge clk); while (in_stall);
        items_sent++;
        op_count[op]++;
    endtask

    initial
    begin : stimulus
        int                  kind;
        int                  n;
        logic                u;
        logic [TAG_BITS-1:0] t;
        bit                  hold_done;
        bit                  pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;

        @(posedge rst_n);
        @(posedge clk);

        // directed: empty peek, confirm with no selection, priority, mismatch, clear
        offer(OP_PEEK, 1'b0, '0);
        offer(OP_CONFIRM, 1'b1, '1);
        offer(OP_PUSH, 1'b1, '1);
        offer(OP_PUSH, 1'b0, '0);
        offer(OP_PEEK, 1'b0, '0);
        offer(OP_PEEK, 1'b1, '0);
        offer(OP_PUSH, 1'b0, 32'h5a5a_a5a5);
        offer(OP_CONFIRM, 1'b0, '0);
        offer(OP_CONFIRM, 1'b0, '1);
        offer(OP_PEEK, 1'b0, '0);
        offer(OP_CONFIRM, 1'b0, '1);
        offer(OP_PEEK, 1'b0, '1);
        offer(OP_CONFIRM, 1'b1, '0);
        offer(OP_PEEK, 1'b0, '0);
        offer(OP_CLEAR, 1'b1, '1);
        offer(OP_CONFIRM, 1'b0, 32'h5a5a_a5a5);
        offer(OP_PEEK, 1'b1, '1);
        offer(OP_CLEAR, 1'b0, '0);

        n = items_sent + RANDOM_ITEMS;
        while (items_sent < n)
        begin
            if (!hold_done && items_sent >= 300)
            begin
                // long receiver hold while items keep coming back to back
                hold_done = 1'b1;
                bursts_on = 1'b0;
                hold_request = 1'b1;
                repeat (40)
                    offer($urandom_range(0, 2) != 0 ? OP_PUSH : OP_PEEK,
                          1'($urandom_range(0, 1)), pick_tag());
                bursts_on = 1'b1;
            end
            if (!pause_done && items_sent >= 550)
            begin
                pause_done = 1'b1;
                in_valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end

            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                offer(OP_PEEK, 1'($urandom_range(0, 1)), pick_tag());
                t = head_to_confirm();
                if ($urandom_range(0, 9) == 0)
                    t[$urandom_range(0, TAG_BITS - 1)] ^= 1'b1;
                offer(OP_CONFIRM, 1'($urandom_range(0, 1)), t);
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(1, 6))
                    offer(OP_PUSH, 1'($urandom_range(0, 1)), pick_tag());
            end
            else if (kind < 78)
            begin
                // fill one queue and push past full
                u = 1'($urandom_range(0, 1));
                n += 0;
                repeat (QUEUE_DEPTH + $urandom_range(1, 2)
                        - (u ? queued_urgent_tags.size() : queued_normal_tags.size()))
                    offer(OP_PUSH, u, pick_tag());
            end
            else if (kind < 86)
            begin
                // drain everything, then one more peek and confirm on empty queues
                repeat (queued_urgent_tags.size() + queued_normal_tags.size() + 1)
                begin
                    offer(OP_PEEK, 1'($urandom_range(0, 1)), pick_tag());
                    offer(OP_CONFIRM, 1'($urandom_range(0, 1)), head_to_confirm());
                end
            end
            else if (kind < 90)
                offer(OP_CLEAR, 1'($urandom_range(0, 1)), pick_tag());
            else
                offer(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_tag());
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);

        $display("covered %0d transfers in (push %0d, peek %0d, confirm %0d, clear %0d), %0d results",
                 items_sent, op_count[OP_PUSH], op_count[OP_PEEK], op_count[OP_CONFIRM],
                 op_count[OP_CLEAR], results_checked);
        $display("status codes reached %b (one bit per code), input held off %0d cycles",
                 status_seen[5:0], input_stall_cycles);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
src/tpq_pkg.sv
src/tpq_ring.sv
src/two_priority_queue_with_confirm.sv
src/tpq_checker.sv
tb/sv/queue_result_checker.sv
tb/sv/tb_two_priority_queue_with_confirm.sv
